>>> sv/qdpd_pkg.sv
// ----------------------------------------------------------------------------
// qdpd_pkg
// Shared constants for the quadratic-divisor polynomial division core.
// ----------------------------------------------------------------------------
package qdpd_pkg;

   // coefficient format, signed fixed point
   localparam int COEF_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   // dividend degree field
   localparam int DEG_WIDTH = 3;

   // quotient bits resolved by each divider stage
   localparam int DIV_BITS_PER_STAGE = 2;

endpackage

>>> sv/quadratic_divisor_poly_division_core.sv
// ----------------------------------------------------------------------------
// quadratic_divisor_poly_division_core
// Divides a dividend polynomial of degree up to 5 by a*x^2 + b*x + c with
// Horner synthetic division in signed fixed point, giving four quotient and
// two remainder coefficients, saturated, and a flag for a zero a.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake            payload
//   req_      in          req_valid/req_stall  degree, c5..c0, sq, lin, const
//   rsp_      out         rsp_valid/rsp_stall  q3..q0, r1, r0, zero_divisor
//
// One beat enters per cycle while req_stall is low. Coefficients use the
// default Q16.16 format. The pipeline is the entry stage, then the four chained
// dividers, each resolving two quotient bits per stage and each followed by
// a multiply, a scale and a sum stage.
// Reset (synchronous, active high) clears every valid bit in the pipeline, the
// output register and the skid register. A response stall first parks one
// beat in the skid register; req_stall is that register's valid flag, so the
// request side sees a registered stall and the whole pipeline holds in place.
// ----------------------------------------------------------------------------
module quadratic_divisor_poly_division_core #(
   parameter int COEF_WIDTH = qdpd_pkg::COEF_WIDTH,
   parameter int FRAC_BITS  = qdpd_pkg::FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [qdpd_pkg::DEG_WIDTH-1:0]      req_dividend_degree,
   input  logic signed [COEF_WIDTH-1:0]        req_dividend_c5,
   input  logic signed [COEF_WIDTH-1:0]        req_dividend_c4,
   input  logic signed [COEF_WIDTH-1:0]        req_dividend_c3,
   input  logic signed [COEF_WIDTH-1:0]        req_dividend_c2,
   input  logic signed [COEF_WIDTH-1:0]        req_dividend_c1,
   input  logic signed [COEF_WIDTH-1:0]        req_dividend_c0,
   input  logic signed [COEF_WIDTH-1:0]        req_divisor_sq,
   input  logic signed [COEF_WIDTH-1:0]        req_divisor_lin,
   input  logic signed [COEF_WIDTH-1:0]        req_divisor_const,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [COEF_WIDTH-1:0]        rsp_quot_q3,
   output logic signed [COEF_WIDTH-1:0]        rsp_quot_q2,
   output logic signed [COEF_WIDTH-1:0]        rsp_quot_q1,
   output logic signed [COEF_WIDTH-1:0]        rsp_quot_q0,
   output logic signed [COEF_WIDTH-1:0]        rsp_rem_r1,
   output logic signed [COEF_WIDTH-1:0]        rsp_rem_r0,
   output logic                                rsp_zero_divisor
);

   localparam int W  = COEF_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int PWD = 2 * W + 2;   // product width

   localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

   // everything a beat carries down the chain besides the live numerator
   typedef struct packed {
      logic                zero;
      logic [W-1:0]        a;
      logic [W-1:0]        b;
      logic [W-1:0]        c;
      logic [4:0][W-1:0]   dl;   // d4..d0 after degree masking
      logic [3:0][W-1:0]   q;    // quotient coefficients found so far
      logic [W-1:0]        tc;   // pending c-term for the next sum
   } ctx_type;

   typedef struct packed {
      logic [W-1:0] q3;
      logic [W-1:0] q2;
      logic [W-1:0] q1;
      logic [W-1:0] q0;
      logic [W-1:0] r1;
      logic [W-1:0] r0;
      logic         zero;
   } rsp_type;

   localparam int CW = $bits(ctx_type);

   // sign-extend a coefficient by two bits for a three-operand sum
   function automatic logic [W+1:0] ext2(input logic [W-1:0] x);
      return {{2{x[W-1]}}, x};
   endfunction

   // clamp a (W+2)-bit sum into the coefficient range
   function automatic logic [W-1:0] sat_w2(input logic [W+1:0] x);
      if ((&x[W+1:W-1]) || !(|x[W+1:W-1])) begin
         return x[W-1:0];
      end else if (x[W+1]) begin
         return MINV;
      end else begin
         return MAXV;
      end
   endfunction

   // floor(p / 2^F), clamped into the coefficient range
   function automatic logic [W-1:0] term_sat(input logic [PWD-1:0] p);
      logic [PWD-1:0] sh;
      sh = $signed(p) >>> F;
      if ((&sh[PWD-1:W-1]) || !(|sh[PWD-1:W-1])) begin
         return sh[W-1:0];
      end else if (sh[PWD-1]) begin
         return MINV;
      end else begin
         return MAXV;
      end
   endfunction

   // pipeline advance: hold everything while the skid register is occupied
   logic adv;

   // entry stage
   ctx_type      ent_ctx_in;
   ctx_type      ent_ctx_ff;
   logic         ent_v_ff;
   logic [W-1:0] ent_num_in;
   logic [W-1:0] ent_num_ff;

   // last sum stage of each level
   logic         s_v_ff   [4];
   logic [W-1:0] s_num_ff [4];
   ctx_type      s_ctx_ff [4];

   // output register and skid register
   rsp_type fin;
   rsp_type out_ff;
   rsp_type skid_ff;
   logic    out_v_ff;
   logic    skid_v_ff;
   logic    beat_out;
   logic    out_take;

   assign adv       = !skid_v_ff;
   assign req_stall = skid_v_ff;

   // mask coefficients above the degree; degrees six and seven act as five
   always_comb begin
      ent_ctx_in       = '0;
      ent_ctx_in.zero  = (req_divisor_sq == '0);
      ent_ctx_in.a     = req_divisor_sq;
      ent_ctx_in.b     = req_divisor_lin;
      ent_ctx_in.c     = req_divisor_const;
      ent_ctx_in.dl[4] = (req_dividend_degree >= 3'd4) ? req_dividend_c4 : '0;
      ent_ctx_in.dl[3] = (req_dividend_degree >= 3'd3) ? req_dividend_c3 : '0;
      ent_ctx_in.dl[2] = (req_dividend_degree >= 3'd2) ? req_dividend_c2 : '0;
      ent_ctx_in.dl[1] = (req_dividend_degree >= 3'd1) ? req_dividend_c1 : '0;
      ent_ctx_in.dl[0] = req_dividend_c0;
      ent_num_in       = (req_dividend_degree >= 3'd5) ? req_dividend_c5 : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_v_ff <= 1'b0;
      end else if (adv) begin
         ent_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ent_ctx_ff <= ent_ctx_in;
         ent_num_ff <= ent_num_in;
      end
   end

   // Four levels, one per quotient coefficient, q3 first. Each level divides,
   // then multiplies the new quotient by -b and -c, scales and clamps the
   // products, and sums the next numerator (or the remainder r1 at the end).
   for (genvar L = 0; L < 4; L++) begin : gen_lvl
      logic          din_v;
      logic [W-1:0]  din_num;
      ctx_type       din_ctx;
      logic          dv_v;
      logic [W-1:0]  dv_q;
      logic [CW-1:0] dv_side;
      ctx_type       dctx;

      logic [W:0]     qx;
      logic [W:0]     nb;
      logic [W:0]     nc;
      ctx_type        m_ctx_in;
      logic           m_v_ff;
      ctx_type        m_ctx_ff;
      logic [PWD-1:0] m_pb_ff;
      logic [PWD-1:0] m_pc_ff;

      logic           t_v_ff;
      ctx_type        t_ctx_ff;
      logic [W-1:0]   t_tb_ff;
      logic [W-1:0]   t_tc_ff;

      ctx_type        s_ctx_in;

      if (L == 0) begin : gen_src_ent
         assign din_v   = ent_v_ff;
         assign din_num = ent_num_ff;
         assign din_ctx = ent_ctx_ff;
      end else begin : gen_src_lvl
         assign din_v   = s_v_ff[L-1];
         assign din_num = s_num_ff[L-1];
         assign din_ctx = s_ctx_ff[L-1];
      end

      qdpd_div #(
         .W  (W),
         .F  (F),
         .SW (CW)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (din_v),
         .in_num    (din_num),
         .in_den    (din_ctx.a),
         .in_side   (din_ctx),
         .out_valid (dv_v),
         .out_quot  (dv_q),
         .out_side  (dv_side)
      );

      assign dctx = ctx_type'(dv_side);

      // multiply stage
      assign qx = {dv_q[W-1], dv_q};
      assign nb = ~{dctx.b[W-1], dctx.b} + (W+1)'(1);
      assign nc = ~{dctx.c[W-1], dctx.c} + (W+1)'(1);

      always_comb begin
         m_ctx_in          = dctx;
         m_ctx_in.q[3-L]   = dv_q;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            m_v_ff <= 1'b0;
            t_v_ff <= 1'b0;
            s_v_ff[L] <= 1'b0;
         end else if (adv) begin
            m_v_ff <= dv_v;
            t_v_ff <= m_v_ff;
            s_v_ff[L] <= t_v_ff;
         end
      end

      // (W+1) by (W+1) signed products
      always_ff @(posedge clock) begin
         if (adv) begin
            m_ctx_ff <= m_ctx_in;
            m_pb_ff  <= PWD'($signed(qx) * $signed(nb));
            m_pc_ff  <= PWD'($signed(qx) * $signed(nc));
         end
      end

      // scale and clamp stage
      always_ff @(posedge clock) begin
         if (adv) begin
            t_ctx_ff <= m_ctx_ff;
            t_tb_ff  <= term_sat(m_pb_ff);
            t_tc_ff  <= term_sat(m_pc_ff);
         end
      end

      // sum stage: coefficient + pending c-term + new b-term
      always_comb begin
         s_ctx_in    = t_ctx_ff;
         s_ctx_in.tc = t_tc_ff;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            s_num_ff[L] <= sat_w2(ext2(t_ctx_ff.dl[4-L]) + ext2(t_ctx_ff.tc)
                                  + ext2(t_tb_ff));
            s_ctx_ff[L] <= s_ctx_in;
         end
      end
   end

   // assemble the response; a zero a forces every coefficient to zero
   always_comb begin
      if (s_ctx_ff[3].zero) begin
         fin      = '0;
         fin.zero = 1'b1;
      end else begin
         fin.q3   = s_ctx_ff[3].q[3];
         fin.q2   = s_ctx_ff[3].q[2];
         fin.q1   = s_ctx_ff[3].q[1];
         fin.q0   = s_ctx_ff[3].q[0];
         fin.r1   = s_num_ff[3];
         fin.r0   = sat_w2(ext2(s_ctx_ff[3].dl[0]) + ext2(s_ctx_ff[3].tc));
         fin.zero = 1'b0;
      end
   end

   // output register with a one-deep skid behind it
   assign beat_out = s_v_ff[3] && adv;
   assign out_take = !out_v_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_take) begin
         if (skid_v_ff) begin
            // drain the parked beat; the pipeline held this cycle
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= beat_out;
         end
      end else if (beat_out) begin
         // output is stalled: park the beat that was already on its way
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         out_ff <= skid_v_ff ? skid_ff : fin;
      end else if (beat_out) begin
         skid_ff <= fin;
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_quot_q3      = out_ff.q3;
   assign rsp_quot_q2      = out_ff.q2;
   assign rsp_quot_q1      = out_ff.q1;
   assign rsp_quot_q0      = out_ff.q0;
   assign rsp_rem_r1       = out_ff.r1;
   assign rsp_rem_r0       = out_ff.r0;
   assign rsp_zero_divisor = out_ff.zero;

endmodule

>>> sv/qdpd_div.sv
// ----------------------------------------------------------------------------
// qdpd_div
// Pipelined signed fixed-point divider: sat(trunc(num * 2^F / den)).
// Restoring division on magnitudes, a fixed number of quotient bits per stage,
// with a sideband word carried alongside each beat.
// ----------------------------------------------------------------------------
module qdpd_div #(
   parameter int W  = qdpd_pkg::COEF_WIDTH,
   parameter int F  = qdpd_pkg::FRAC_BITS,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  logic [W-1:0]  in_num,
   input  logic [W-1:0]  in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [W-1:0]  out_quot,
   output logic [SW-1:0] out_side
);

   localparam int NW     = W + F;
   localparam int BPS    = qdpd_pkg::DIV_BITS_PER_STAGE;
   localparam int STAGES = (NW + BPS - 1) / BPS;
   localparam int PW     = STAGES * BPS;
   localparam int RW     = W + 1;

   localparam logic [PW-1:0] POS_LIM = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [PW-1:0] NEG_LIM = POS_LIM + PW'(1);
   localparam logic [W-1:0]  MAXV    = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  MINV    = {1'b1, {(W-1){1'b0}}};

   logic [STAGES:0] v_ff;
   logic [STAGES:0] neg_ff;
   logic [PW-1:0]   work_ff [STAGES+1];
   logic [RW-1:0]   rem_ff  [STAGES];
   logic [W-1:0]    den_ff  [STAGES+1];
   logic [SW-1:0]   side_ff [STAGES+1];

   logic [W-1:0] num_mag;
   logic [W-1:0] den_mag;
   logic [W-1:0] quot_in;
   logic [PW-1:0] mag;

   logic          out_v_ff;
   logic [W-1:0]  out_quot_ff;
   logic [SW-1:0] out_side_ff;

   // entry: take magnitudes, line the numerator up above the fraction bits
   assign num_mag = in_num[W-1] ? (~in_num + W'(1)) : in_num;
   assign den_mag = in_den[W-1] ? (~in_den + W'(1)) : in_den;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         work_ff[0] <= PW'(num_mag) << F;
         rem_ff[0]  <= '0;
         den_ff[0]  <= den_mag;
         neg_ff[0]  <= in_num[W-1] ^ in_den[W-1];
         side_ff[0] <= in_side;
      end
   end

   for (genvar s = 1; s <= STAGES; s++) begin : gen_stage
      logic [RW-1:0] rem_in;
      logic [PW-1:0] work_in;

      // shift one numerator bit in, subtract when it fits, per quotient bit
      always_comb begin
         rem_in  = rem_ff[s-1];
         work_in = work_ff[s-1];
         for (int j = 0; j < BPS; j++) begin
            rem_in  = {rem_in[RW-2:0], work_in[PW-1]};
            work_in = {work_in[PW-2:0], 1'b0};
            if (rem_in >= {1'b0, den_ff[s-1]}) begin
               rem_in     = rem_in - {1'b0, den_ff[s-1]};
               work_in[0] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv) begin
            v_ff[s] <= v_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            work_ff[s] <= work_in;
            den_ff[s]  <= den_ff[s-1];
            neg_ff[s]  <= neg_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end

      if (s < STAGES) begin : gen_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[s] <= rem_in;
            end
         end
      end
   end

   // restore the sign and clamp to the coefficient range
   assign mag = work_ff[STAGES];

   always_comb begin
      if (neg_ff[STAGES]) begin
         quot_in = (mag > NEG_LIM) ? MINV : (~mag[W-1:0] + W'(1));
      end else begin
         quot_in = (mag > POS_LIM) ? MAXV : mag[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= v_ff[STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_quot_ff <= quot_in;
         out_side_ff <= side_ff[STAGES];
      end
   end

   assign out_valid = out_v_ff;
   assign out_quot  = out_quot_ff;
   assign out_side  = out_side_ff;

endmodule

>>> sv/qdpd_checker.sv
// ----------------------------------------------------------------------------
// qdpd_checker
// Port-level checks for the quadratic-divisor polynomial division core.
// ----------------------------------------------------------------------------
module qdpd_checker #(
   parameter int COEF_WIDTH = qdpd_pkg::COEF_WIDTH
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [COEF_WIDTH-1:0] rsp_quot_q3,
   input logic [COEF_WIDTH-1:0] rsp_quot_q2,
   input logic [COEF_WIDTH-1:0] rsp_quot_q1,
   input logic [COEF_WIDTH-1:0] rsp_quot_q0,
   input logic [COEF_WIDTH-1:0] rsp_rem_r1,
   input logic [COEF_WIDTH-1:0] rsp_rem_r0,
   input logic                  rsp_zero_divisor
);

   // a zero-divisor response carries no coefficients
   a_zero_clears : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_divisor |->
         rsp_quot_q3 == '0 && rsp_quot_q2 == '0 && rsp_quot_q1 == '0 &&
         rsp_quot_q0 == '0 && rsp_rem_r1 == '0 && rsp_rem_r0 == '0)
      else $error("zero divisor response with nonzero coefficients");

   // a stalled response beat holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_quot_q3) && $stable(rsp_quot_q0) &&
         $stable(rsp_rem_r1) && $stable(rsp_rem_r0) && $stable(rsp_zero_divisor))
      else $error("stalled response beat changed");

   // the request side only stalls while a response is waiting
   a_stall_needs_rsp : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no response pending");

   // the request stall rises only after the response side held a beat
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("request stall without a response stall");

   // reset empties the output register and the skid register
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("valid or stall left set after reset");

endmodule

bind quadratic_divisor_poly_division_core qdpd_checker #(
   .COEF_WIDTH (COEF_WIDTH)
) u_qdpd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_quot_q3      (rsp_quot_q3),
   .rsp_quot_q2      (rsp_quot_q2),
   .rsp_quot_q1      (rsp_quot_q1),
   .rsp_quot_q0      (rsp_quot_q0),
   .rsp_rem_r1       (rsp_rem_r1),
   .rsp_rem_r0       (rsp_rem_r0),
   .rsp_zero_divisor (rsp_zero_divisor)
);

>>> dv/quadratic_divisor_poly_division_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadratic_divisor_poly_division_core_tb
// Drives dividend and divisor beats into the division core and checks every
// response field against a fixed-point Horner predictor, or against the stated
// answer of a typed row. A short table of edge cases comes first, then shaped
// random beats, with random request gaps and random response stalls.
// ----------------------------------------------------------------------------
module quadratic_divisor_poly_division_core_tb;

   typedef logic signed [qdpd_pkg::COEF_WIDTH-1:0] coef_type;

   // one request beat; dc[k] is the x^k coefficient
   typedef struct {
      logic [qdpd_pkg::DEG_WIDTH-1:0] deg;
      coef_type                       dc [6];
      coef_type                       a;
      coef_type                       b;
      coef_type                       c;
   } poly_req_type;

   // one response beat; q[k] is the quotient x^k coefficient
   typedef struct {
      coef_type q [4];
      coef_type r1;
      coef_type r0;
      logic     zd;
   } quot_rem_type;

   // directed row: typed rows carry their own answer
   typedef struct {
      poly_req_type req;
      bit           typed;
      quot_rem_type want;
   } stim_row_type;

   localparam longint COEF_MAX = (longint'(1) <<< (qdpd_pkg::COEF_WIDTH - 1)) - 1;
   localparam longint COEF_MIN = -COEF_MAX - 1;
   localparam coef_type COEF_HI = coef_type'(COEF_MAX);
   localparam coef_type COEF_LO = coef_type'(COEF_MIN);
   localparam coef_type ONE_Q   = coef_type'(longint'(1) <<< qdpd_pkg::FRAC_BITS);
   localparam int     RANDOM_BEATS   = 1500;
   localparam int     DRAIN_CYCLES   = 130;   // a bit over the pipeline depth
   localparam int     WATCHDOG_LIMIT = 4000;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [qdpd_pkg::DEG_WIDTH-1:0] req_dividend_degree;
   coef_type             req_dividend_c5, req_dividend_c4, req_dividend_c3;
   coef_type             req_dividend_c2, req_dividend_c1, req_dividend_c0;
   coef_type             req_divisor_sq, req_divisor_lin, req_divisor_const;
   logic                 rsp_valid;
   logic                 rsp_stall;
   coef_type             rsp_quot_q3, rsp_quot_q2, rsp_quot_q1, rsp_quot_q0;
   coef_type             rsp_rem_r1, rsp_rem_r0;
   logic                 rsp_zero_divisor;

   quot_rem_type quot_rem_q [$];   // expected responses, oldest first
   stim_row_type stim_table [$];
   int           err_count;
   int           idle_cycles;
   bit           quiet;            // no gaps and no stalls while set

   quadratic_divisor_poly_division_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_dividend_degree (req_dividend_degree),
      .req_dividend_c5     (req_dividend_c5),
      .req_dividend_c4     (req_dividend_c4),
      .req_dividend_c3     (req_dividend_c3),
      .req_dividend_c2     (req_dividend_c2),
      .req_dividend_c1     (req_dividend_c1),
      .req_dividend_c0     (req_dividend_c0),
      .req_divisor_sq      (req_divisor_sq),
      .req_divisor_lin     (req_divisor_lin),
      .req_divisor_const   (req_divisor_const),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_quot_q3         (rsp_quot_q3),
      .rsp_quot_q2         (rsp_quot_q2),
      .rsp_quot_q1         (rsp_quot_q1),
      .rsp_quot_q0         (rsp_quot_q0),
      .rsp_rem_r1          (rsp_rem_r1),
      .rsp_rem_r0          (rsp_rem_r0),
      .rsp_zero_divisor    (rsp_zero_divisor)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ------------------------------------------------------------------------
   // Predictor: Horner division in signed fixed point, 64-bit intermediates
   // ------------------------------------------------------------------------
   function automatic longint clamp(longint v);
      if (v > COEF_MAX) return COEF_MAX;
      if (v < COEF_MIN) return COEF_MIN;
      return v;
   endfunction

   // floor(q * -v / 2^F): round negative products down, not toward zero
   function automatic longint back_term(longint q, longint v);
      longint p;
      p = q * (-v);
      if (p >= 0) return clamp(p >>> qdpd_pkg::FRAC_BITS);
      return clamp(-((-p + ((longint'(1) <<< qdpd_pkg::FRAC_BITS) - 1))
                     >>> qdpd_pkg::FRAC_BITS));
   endfunction

   // SV division truncates toward zero, as the hardware divider must
   function automatic longint lead_div(longint num, longint a);
      longint n;
      n = clamp(num) * (longint'(1) <<< qdpd_pkg::FRAC_BITS);
      return clamp(n / a);
   endfunction

   function automatic quot_rem_type divide_poly(poly_req_type r);
      quot_rem_type o;
      longint       d [6];
      longint       a, b, c, q3, q2, q1, q0;
      int           deg;
      deg = (r.deg > 5) ? 5 : int'(r.deg);
      for (int k = 0; k < 6; k++) d[k] = (k > deg) ? 0 : longint'(r.dc[k]);
      a = r.a;
      b = r.b;
      c = r.c;
      o.zd = (a == 0);
      if (a == 0) begin
         foreach (o.q[k]) o.q[k] = '0;
         o.r1 = '0;
         o.r0 = '0;
         return o;
      end
      q3 = lead_div(d[5], a);
      q2 = lead_div(d[4] + back_term(q3, b), a);
      q1 = lead_div(d[3] + back_term(q3, c) + back_term(q2, b), a);
      q0 = lead_div(d[2] + back_term(q2, c) + back_term(q1, b), a);
      o.q[3] = coef_type'(q3);
      o.q[2] = coef_type'(q2);
      o.q[1] = coef_type'(q1);
      o.q[0] = coef_type'(q0);
      o.r1   = coef_type'(clamp(d[1] + back_term(q1, c) + back_term(q0, b)));
      o.r0   = coef_type'(clamp(d[0] + back_term(q0, c)));
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic poly_req_type mk_req(int deg, coef_type c5, coef_type c4,
                                           coef_type c3, coef_type c2, coef_type c1,
                                           coef_type c0, coef_type a, coef_type b,
                                           coef_type c);
      poly_req_type r;
      r.deg   = qdpd_pkg::DEG_WIDTH'(deg);
      r.dc[5] = c5;
      r.dc[4] = c4;
      r.dc[3] = c3;
      r.dc[2] = c2;
      r.dc[1] = c1;
      r.dc[0] = c0;
      r.a = a;
      r.b = b;
      r.c = c;
      return r;
   endfunction

   function automatic quot_rem_type mk_resp(coef_type r1, coef_type r0, logic zd);
      quot_rem_type o;
      foreach (o.q[k]) o.q[k] = '0;
      o.r1 = r1;
      o.r0 = r0;
      o.zd = zd;
      return o;
   endfunction

   task automatic add_row(poly_req_type r, bit typed, quot_rem_type want);
      stim_row_type s;
      s.req   = r;
      s.typed = typed;
      s.want  = want;
      stim_table.push_back(s);
   endtask

   // mix of full-range, mid-size, integral and extreme coefficients
   function automatic coef_type rand_coef();
      case ($urandom_range(0, 9))
         0, 1, 2: return coef_type'($urandom);
         3, 4, 5: return coef_type'(longint'($urandom_range(0, 1 << 22)) - (1 << 21));
         6, 7:    return coef_type'((longint'($urandom_range(0, 64)) - 32)
                                    <<< qdpd_pkg::FRAC_BITS);
         8:       return $urandom_range(0, 1) ? COEF_HI : COEF_LO;
         default: return coef_type'($urandom_range(0, 3)) - 1;
      endcase
   endfunction

   function automatic poly_req_type rand_req();
      poly_req_type r;
      r.deg = ($urandom_range(0, 15) < 12)
              ? qdpd_pkg::DEG_WIDTH'($urandom_range(2, 5))
              : qdpd_pkg::DEG_WIDTH'($urandom_range(0, 7));
      foreach (r.dc[k]) r.dc[k] = rand_coef();
      r.a = ($urandom_range(0, 19) == 0) ? coef_type'(0) : rand_coef();
      r.b = rand_coef();
      r.c = rand_coef();
      return r;
   endfunction

   // mostly short gaps, a few long
   function automatic int rand_gap();
      int p;
      if (quiet) return 0;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: drive one beat and hold it until accepted
   // ------------------------------------------------------------------------
   task automatic send_beat(poly_req_type r, bit typed, quot_rem_type want);
      int gap;
      gap = rand_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_dividend_degree <= r.deg;
      req_dividend_c5     <= r.dc[5];
      req_dividend_c4     <= r.dc[4];
      req_dividend_c3     <= r.dc[3];
      req_dividend_c2     <= r.dc[2];
      req_dividend_c1     <= r.dc[1];
      req_dividend_c0     <= r.dc[0];
      req_divisor_sq      <= r.a;
      req_divisor_lin     <= r.b;
      req_divisor_const   <= r.c;
      // hold until the edge that sees valid with no stall
      do @(posedge clock); while (req_stall);
      quot_rem_q.push_back(typed ? want : divide_poly(r));
   endtask

   task automatic report_mismatch(string field, coef_type got, coef_type want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      err_count++;
   endtask

   // ------------------------------------------------------------------------
   // Response side: random stalls, compare each accepted beat in order
   // ------------------------------------------------------------------------
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (quot_rem_q.size() == 0) begin
               $display("unexpected response beat at %0t", $realtime);
               err_count++;
            end else begin
               quot_rem_type w;
               w = quot_rem_q.pop_front();
               if (rsp_quot_q3 !== w.q[3]) report_mismatch("quot_q3", rsp_quot_q3, w.q[3]);
               if (rsp_quot_q2 !== w.q[2]) report_mismatch("quot_q2", rsp_quot_q2, w.q[2]);
               if (rsp_quot_q1 !== w.q[1]) report_mismatch("quot_q1", rsp_quot_q1, w.q[1]);
               if (rsp_quot_q0 !== w.q[0]) report_mismatch("quot_q0", rsp_quot_q0, w.q[0]);
               if (rsp_rem_r1 !== w.r1) report_mismatch("rem_r1", rsp_rem_r1, w.r1);
               if (rsp_rem_r0 !== w.r0) report_mismatch("rem_r0", rsp_rem_r0, w.r0);
               if (rsp_zero_divisor !== w.zd)
                  report_mismatch("zero_divisor", coef_type'(rsp_zero_divisor),
                                  coef_type'(w.zd));
            end
         end
         // pick the next stall window once the current one runs out
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            int p;
            p = $urandom_range(0, 99);
            if (p < 65) begin
               rsp_stall <= 1'b0;
            end else begin
               rsp_stall  <= 1'b1;
               stall_left <= (p < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: count cycles with no beat moving on either channel
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d responses outstanding", quot_rem_q.size());
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      quot_rem_type none;
      none                = mk_resp('0, '0, 1'b0);
      err_count           = 0;
      idle_cycles         = 0;
      quiet               = 1'b0;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_dividend_degree = '0;
      {req_dividend_c5, req_dividend_c4, req_dividend_c3} = '0;
      {req_dividend_c2, req_dividend_c1, req_dividend_c0} = '0;
      {req_divisor_sq, req_divisor_lin, req_divisor_const} = '0;

      // zero dividend over a unit divisor: nothing at all comes out
      add_row(mk_req(5, 0, 0, 0, 0, 0, 0, ONE_Q, 0, 0), 1'b1, none);
      // zero a: every field zero and the flag up, whatever else is driven
      add_row(mk_req(5, COEF_HI, COEF_HI, COEF_HI, COEF_HI, COEF_HI, COEF_HI,
                     0, COEF_HI, COEF_HI), 1'b1, mk_resp('0, '0, 1'b1));
      add_row(mk_req(7, COEF_LO, COEF_LO, COEF_LO, COEF_LO, COEF_LO, COEF_LO,
                     0, COEF_LO, COEF_LO), 1'b1, mk_resp('0, '0, 1'b1));
      // degree below two: quotient zero, remainder is the dividend itself
      add_row(mk_req(0, -1, -1, -1, -1, COEF_HI, COEF_LO, ONE_Q, ONE_Q, ONE_Q),
              1'b1, mk_resp('0, COEF_LO, 1'b0));
      add_row(mk_req(1, COEF_HI, COEF_LO, 1, -1, COEF_LO, COEF_HI, -ONE_Q, 3, 5),
              1'b1, mk_resp(COEF_LO, COEF_HI, 1'b0));
      // each degree from two to five, and the two codes that act as degree five
      for (int d = 2; d < 8; d++)
         add_row(mk_req(d, 2 * ONE_Q, -3 * ONE_Q, ONE_Q, 7 * ONE_Q, -ONE_Q, 4 * ONE_Q,
                        ONE_Q, -2 * ONE_Q, 3 * ONE_Q), 1'b0, none);
      // exact case: x^3 - x over x^2 - 1
      add_row(mk_req(3, 0, 0, ONE_Q, 0, -ONE_Q, 0, ONE_Q, 0, -ONE_Q), 1'b0, none);
      // saturation at both rails, tiny and huge divisors
      add_row(mk_req(5, COEF_HI, COEF_HI, COEF_HI, COEF_HI, COEF_HI, COEF_HI,
                     1, COEF_HI, COEF_HI), 1'b0, none);
      add_row(mk_req(5, COEF_LO, COEF_LO, COEF_LO, COEF_LO, COEF_LO, COEF_LO,
                     -1, COEF_LO, COEF_LO), 1'b0, none);
      add_row(mk_req(5, COEF_LO, COEF_HI, COEF_LO, COEF_HI, COEF_LO, COEF_HI,
                     COEF_LO, COEF_LO, COEF_HI), 1'b0, none);
      add_row(mk_req(4, -1, COEF_LO, COEF_HI, -1, 1, -1,
                     COEF_HI, COEF_LO, COEF_LO), 1'b0, none);
      // negative products that must round down, not toward zero
      add_row(mk_req(5, 3, -5, 7, -9, 11, -13, 3, 1, -1), 1'b0, none);
      add_row(mk_req(5, -ONE_Q, ONE_Q / 3, -ONE_Q / 7, 5, -7, 9,
                     ONE_Q / 2, -ONE_Q / 3, ONE_Q / 5), 1'b0, none);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // walk the table of edge cases
      foreach (stim_table[i]) send_beat(stim_table[i].req, stim_table[i].typed,
                                        stim_table[i].want);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         // stretches with no idling on either side
         quiet = ((n >= 300) && (n < 450)) || ((n >= 900) && (n < 1000));
         if (n == 700) begin
            // hold off the sender until the pipeline has drained
            req_valid <= 1'b0;
            do @(posedge clock); while (quot_rem_q.size() != 0);
         end
         send_beat(rand_req(), 1'b0, none);
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      // drain outstanding responses, then let the pipeline settle
      do @(posedge clock); while (quot_rem_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0 && quot_rem_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/qdpd_pkg.sv
sv/qdpd_div.sv
sv/quadratic_divisor_poly_division_core.sv
sv/qdpd_checker.sv
dv/quadratic_divisor_poly_division_core_tb.sv
